/* design/sma_pkg.sv */
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the stack machine arithmetic unit.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned OpW           = 3;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned DepthW        = 7;
  localparam int unsigned IterW         = $clog2(DataW);
  localparam int unsigned StackDepthDef = 64;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MUL  = 3'd4,
    OP_MOD  = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // request from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

endpackage

/* design/sma_if.sv */
// ----------------------------------------------------------------------------
// sma_if
// Valid/ready channels of the stack machine: command in, response out.
// ----------------------------------------------------------------------------
interface sma_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface sma_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] top_value;
  logic [6:0]         depth;

  modport source (output valid, output status, output top_value, output depth,
                  input ready);
  modport sink   (input valid, input status, input top_value, input depth,
                  output ready);
endinterface

/* design/sma_stack.sv */
// ----------------------------------------------------------------------------
// sma_stack
// Stack storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sma_stack #(
  parameter int unsigned StackDepth = 64,
  parameter int unsigned IdxW       = $clog2(StackDepth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [IdxW-1:0]          waddr_i,
  input  logic [sma_pkg::DataW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [IdxW-1:0]          raddr_i,
  output logic [sma_pkg::DataW-1:0] rdata_o
);
  import sma_pkg::*;

  logic [DataW-1:0] mem_q [StackDepth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sma_alu.sv */
// ----------------------------------------------------------------------------
// sma_alu
// Shared 33-bit adder sequenced for add, sub, shift-add multiply and
// restoring signed divide / remainder.
// ----------------------------------------------------------------------------
module sma_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sma_pkg::alu_req_t         req_i,
  input  logic [sma_pkg::DataW-1:0] s_i,
  input  logic [sma_pkg::DataW-1:0] t_i,
  output logic                      done_o,
  output logic [sma_pkg::DataW-1:0] result_o
);
  import sma_pkg::*;

  typedef enum logic [6:0] {
    A_IDLE  = 7'b0000001,
    A_ADD   = 7'b0000010,
    A_MUL   = 7'b0000100,
    A_ABS_S = 7'b0001000,
    A_ABS_T = 7'b0010000,
    A_DIV   = 7'b0100000,
    A_FIX   = 7'b1000000
  } alu_state_e;

  localparam logic [IterW-1:0] IterLast = IterW'(DataW - 1);

  alu_state_e       state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [DataW-1:0] a_q, b_q, acc_q, res_q;
  op_e              op_q;
  logic             neg_q;

  logic [DataW-1:0] add_x, add_y, rem_sh, fix_src;
  logic             add_inv;
  logic [DataW:0]   sum;
  logic             ge;

  assign rem_sh  = {acc_q[DataW-2:0], a_q[DataW-1]};
  assign fix_src = (op_q == OP_DIV) ? a_q : acc_q;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_inv = 1'b0;
    unique case (state_q)
      A_ADD: begin
        add_x   = a_q;
        add_y   = b_q;
        add_inv = (op_q == OP_SUB);
      end
      A_MUL: begin
        add_x = acc_q;
        add_y = a_q;
      end
      A_ABS_S: begin
        add_y   = a_q;
        add_inv = 1'b1;
      end
      A_ABS_T: begin
        add_y   = b_q;
        add_inv = 1'b1;
      end
      A_DIV: begin
        add_x   = rem_sh;
        add_y   = b_q;
        add_inv = 1'b1;
      end
      A_FIX: begin
        add_y   = fix_src;
        add_inv = neg_q;
      end
      default: begin
        add_inv = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y ^ {DataW{add_inv}}} + {{DataW{1'b0}}, add_inv};
  // carry out of x + ~y + 1 means x >= y
  assign ge  = sum[DataW];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        cnt_d = '0;
        if (req_i.start) begin
          case (req_i.op)
            OP_MUL:         state_d = A_MUL;
            OP_DIV, OP_MOD: state_d = A_ABS_S;
            default:        state_d = A_ADD;
          endcase
        end
      end
      A_ADD: begin
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_MUL: begin
        cnt_d = cnt_q + IterW'(1);
        if (cnt_q == IterLast) begin
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_ABS_S: state_d = A_ABS_T;
      A_ABS_T: state_d = A_DIV;
      A_DIV: begin
        cnt_d = cnt_q + IterW'(1);
        if (cnt_q == IterLast) begin
          state_d = A_FIX;
        end
      end
      A_FIX: begin
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          a_q   <= s_i;
          b_q   <= t_i;
          acc_q <= '0;
          op_q  <= req_i.op;
          // quotient sign from both operands, remainder sign from dividend
          neg_q <= (req_i.op == OP_DIV) ? (s_i[DataW-1] ^ t_i[DataW-1]) : s_i[DataW-1];
        end
      end
      A_ADD: res_q <= sum[DataW-1:0];
      A_MUL: begin
        if (b_q[0]) begin
          acc_q <= sum[DataW-1:0];
        end
        a_q <= {a_q[DataW-2:0], 1'b0};
        b_q <= {1'b0, b_q[DataW-1:1]};
        if (cnt_q == IterLast) begin
          res_q <= b_q[0] ? sum[DataW-1:0] : acc_q;
        end
      end
      A_ABS_S: begin
        if (a_q[DataW-1]) begin
          a_q <= sum[DataW-1:0];
        end
      end
      A_ABS_T: begin
        if (b_q[DataW-1]) begin
          b_q <= sum[DataW-1:0];
        end
      end
      A_DIV: begin
        acc_q <= ge ? sum[DataW-1:0] : rem_sh;
        a_q   <= {a_q[DataW-2:0], ge};
      end
      A_FIX: res_q <= sum[DataW-1:0];
      default: res_q <= res_q;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* design/stack_machine_arith_unit.sv */
// ----------------------------------------------------------------------------
// stack_machine_arith_unit
// Integer stack machine: push plus add, sub, mul, div and mod on the top two
// entries, with one status and top-of-stack response per command.
// ----------------------------------------------------------------------------
// usage:
//   cmd_i carries opcode and push_value, rsp_o carries status, top_value and
//   depth; each command gives exactly one response, in order.
//   the unit takes one command at a time and drops cmd_i.ready from the
//   transfer until its response is loaded into the output register.
//   work per command after the transfer:
//     push or unused opcode ........ decode, then response
//     add / sub .................... stack read, then add or subtract
//     mul .......................... 32 shift-add steps
//     div / mod .................... 2 abs, 32 steps, 1 sign fix
//     errors (short, zero divisor) . respond from decode or check
//   the arithmetic unit runs these on one shared adder, with bit-per-cycle
//   multiply and divide loops.
//   reset empties the stack (depth 0) and clears all pending work; stack
//   storage needs no clearing pass.
//   a stalled response stays in the output register with its payload held;
//   a following command may be taken meanwhile but waits at its end until
//   the register is free.
// ----------------------------------------------------------------------------
module stack_machine_arith_unit #(
  parameter int unsigned StackDepth = sma_pkg::StackDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sma_cmd_if.sink   cmd_i,
  sma_rsp_if.source rsp_o
);
  import sma_pkg::*;

  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned IdxW = $clog2(StackDepth);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_CALC   = 5'b01000,
    S_RESP   = 5'b10000
  } seq_state_e;

  seq_state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;

  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] pv_q, top_q;
  status_e          status_q;
  logic [StatusW-1:0] out_status_q;
  logic [DataW-1:0]   out_top_q;
  logic [DepthW-1:0]  out_depth_q;

  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;
  logic [CntW-1:0]  below_top;
  alu_req_t         alu_req;
  logic             alu_done;
  logic [DataW-1:0] alu_result;

  logic             is_full, is_short, is_divmod, out_free;
  logic [CntW+DepthW-1:0] cnt_ext;

  assign below_top = count_q - CntW'(2);
  assign is_full   = (count_q == CntW'(StackDepth));
  assign is_short  = (count_q < CntW'(2));
  assign is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign cnt_ext   = {{DepthW{1'b0}}, count_q};

  sma_stack #(
    .StackDepth (StackDepth),
    .IdxW       (IdxW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (below_top[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  sma_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .s_i      (mem_rdata),
    .t_i      (top_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = below_top[IdxW-1:0];
    mem_wdata   = alu_result;
    mem_re      = 1'b0;
    alu_req     = '{start: 1'b0, op: op_e'(op_q)};
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_PUSH: begin
            state_d = S_RESP;
            if (!is_full) begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IdxW-1:0];
              mem_wdata = pv_q;
              count_d   = count_q + CntW'(1);
            end
          end
          OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD: begin
            if (is_short) begin
              state_d = S_RESP;
            end else begin
              mem_re  = 1'b1;
              state_d = S_CHECK;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_CHECK: begin
        if (is_divmod && (top_q == '0)) begin
          state_d = S_RESP;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        if (alu_done) begin
          mem_we  = 1'b1;
          count_d = count_q - CntW'(1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_q <= cmd_i.opcode;
          pv_q <= cmd_i.push_value;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_PUSH: begin
            if (is_full) begin
              status_q <= ST_FULL;
            end else begin
              status_q <= ST_OK;
              top_q    <= pv_q;
            end
          end
          OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD: begin
            status_q <= is_short ? ST_SHORT : ST_OK;
          end
          default: status_q <= ST_OK;
        endcase
      end
      S_CHECK: begin
        if (is_divmod && (top_q == '0)) begin
          status_q <= ST_DIVZERO;
        end
      end
      S_CALC: begin
        if (alu_done) begin
          top_q <= alu_result;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_status_q <= status_q;
          out_top_q    <= (count_q == '0) ? '0 : top_q;
          out_depth_q  <= cnt_ext[DepthW-1:0];
        end
      end
      default: top_q <= top_q;
    endcase
  end

  assign cmd_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.top_value = out_top_q;
  assign rsp_o.depth     = out_depth_q;

endmodule

/* design/sma_checker.sv */
// ----------------------------------------------------------------------------
// sma_checker
// Port-level checks of the stack machine, bound to the top level.
// ----------------------------------------------------------------------------
module sma_checker #(
  parameter int unsigned StackDepth = sma_pkg::StackDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] top_value_i,
  input logic [6:0]  depth_i
);
  import sma_pkg::*;

  localparam bit DepthFits = (StackDepth < 128);

  // a stalled response keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(top_value_i) && $stable(depth_i))
    else $error("stalled response changed");

  // the unit is busy in the cycle after a command transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while busy");

  // an empty stack reports zero on top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (depth_i == '0) |-> top_value_i == '0)
    else $error("nonzero top on empty stack");

  // a short-stack error only with fewer than two entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_SHORT) && DepthFits |-> depth_i < 7'd2)
    else $error("short status with enough entries");

  // full status only at capacity, and depth never above capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && DepthFits |-> (depth_i <= 7'(StackDepth))
      && ((status_i != ST_FULL) || (depth_i == 7'(StackDepth))))
    else $error("depth beyond capacity or bad full status");

endmodule

bind stack_machine_arith_unit sma_checker #(
  .StackDepth (StackDepth)
) u_sma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .top_value_i (rsp_o.top_value),
  .depth_i     (rsp_o.depth)
);
